// ===== hdl/assert_macros.svh =====
// Assertion macros used by the polynomial MAC controller.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== hdl/eia1_pkg.sv =====
// Shared types, constants and GF(2^64) helpers for the EIA1 polynomial MAC.
// No dependencies; used by the controller, datapath and top level.
package eia1_pkg;

	localparam int BlockW = 64;
	localparam int TagW = 32;
	localparam int VbitsW = 7;
	localparam int IdxW = 2;
	localparam int MulSteps = 64;
	localparam int CntW = $clog2(MulSteps);
	localparam logic [BlockW-1:0] RedPoly = 64'h1b;

	// register indexes of the write port
	localparam logic [IdxW-1:0] RegKeyP = 2'd0;
	localparam logic [IdxW-1:0] RegKeyQ = 2'd1;
	localparam logic [IdxW-1:0] RegMask = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_POST_P,
		ST_MUL_Q,
		ST_POST_Q
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_blk; // absorb accepted block, start multiply by P
		logic step;     // one shift-xor step of the serial multiplier
		logic save_acc; // product becomes the new accumulator
		logic load_q;   // mix in length, start multiply by Q, clear state
		logic emit;     // capture the tag into the output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_blk; // block in flight closes the message
	} dp_stat_t;

	// multiply by x modulo x^64+x^4+x^3+x+1
	function automatic logic [BlockW-1:0] gf_times_x(input logic [BlockW-1:0] v);
		gf_times_x = {v[BlockW-2:0], 1'b0} ^ (v[BlockW-1] ? RedPoly : '0);
	endfunction

endpackage

// ===== hdl/eia1_polynomial_mac.sv =====
// Top level of the EIA1 / UIA2 polynomial MAC stage.
// Instantiates eia1_ctrl and eia1_dp; uses eia1_pkg.
//
// channel   dir  handshake            content
// s_*       in   s_tvalid/s_tready    tdata: message_block[63:0], valid_bits[70:64]; tlast: final_block
// m_*       out  m_tvalid/m_tready    tdata: mac_tag[31:0]
// wr_*      in   wr_en                wr_index selects key P, key Q, output mask
//
// A non-final block is accepted, then passes through 64 steps of the
// bit-serial GF(2^64) multiplier (one key bit per step) and one update.
// A final block runs a second 64-step multiply by key Q in place of the update.
// The tag waits in an output register; a new block is taken meanwhile, and
// the next tag stalls only if the previous one is still not taken.
// Reset clears keys, accumulator, length count and output valid at once.
module eia1_polynomial_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [71:0]                       s_tdata,   // message_block[63:0], valid_bits[70:64], zero pad
	input  logic                              s_tlast,   // final_block
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [eia1_pkg::TagW-1:0]         m_tdata,   // mac_tag[31:0]
	input  logic                              wr_en,
	input  logic [eia1_pkg::IdxW-1:0]         wr_index,
	input  logic [eia1_pkg::BlockW-1:0]       wr_data
);

	eia1_pkg::dp_cmd_t  cmd;
	eia1_pkg::dp_stat_t stat;
	logic [71:0] unused_pad;

	assign unused_pad = s_tdata;

	eia1_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	eia1_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.message_block (unused_pad[eia1_pkg::BlockW-1:0]),
		.final_block   (s_tlast),
		.valid_bits    (unused_pad[eia1_pkg::BlockW +: eia1_pkg::VbitsW]),
		.cmd           (cmd),
		.stat          (stat),
		.mac_tag       (m_tdata)
	);

endmodule

// ===== hdl/eia1_dp.sv =====
// Datapath of the EIA1 MAC: key registers, accumulator, length counter,
// bit-serial GF(2^64) multiplier and tag register. Uses eia1_pkg.
module eia1_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [eia1_pkg::IdxW-1:0]     wr_index,
	input  logic [eia1_pkg::BlockW-1:0]   wr_data,
	input  logic [eia1_pkg::BlockW-1:0]   message_block,
	input  logic                          final_block,
	input  logic [eia1_pkg::VbitsW-1:0]   valid_bits,
	input  eia1_pkg::dp_cmd_t             cmd,
	output eia1_pkg::dp_stat_t            stat,
	output logic [eia1_pkg::TagW-1:0]     mac_tag
);

	logic [eia1_pkg::BlockW-1:0] key_p_q, key_q_q;
	logic [eia1_pkg::TagW-1:0]   mask_q;
	logic [eia1_pkg::BlockW-1:0] acc_q, total_q;
	logic [eia1_pkg::BlockW-1:0] mul_v_q, mul_k_q, prod_q;
	logic [eia1_pkg::TagW-1:0]   tag_q;
	logic                        last_q;

	logic [eia1_pkg::VbitsW-1:0] n_sat, blk_bits;
	logic [eia1_pkg::BlockW-1:0] lead_mask, blk_masked;

	// leading-bit mask of the final block, count saturates at 64
	always_comb begin
		n_sat = valid_bits[eia1_pkg::VbitsW-1] ? eia1_pkg::VbitsW'(eia1_pkg::BlockW)
			: valid_bits;
		lead_mask = valid_bits[eia1_pkg::VbitsW-1] ? '1
			: ~({eia1_pkg::BlockW{1'b1}} >> valid_bits[eia1_pkg::VbitsW-2:0]);
		blk_masked = final_block ? (message_block & lead_mask) : message_block;
		blk_bits = final_block ? n_sat : eia1_pkg::VbitsW'(eia1_pkg::BlockW);
	end

	// key and mask registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_p_q <= '0;
			key_q_q <= '0;
			mask_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				eia1_pkg::RegKeyP: key_p_q <= wr_data;
				eia1_pkg::RegKeyQ: key_q_q <= wr_data;
				eia1_pkg::RegMask: mask_q <= wr_data[eia1_pkg::TagW-1:0];
				default: ;
			endcase
		end
	end

	// message state: accumulator and running bit length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			total_q <= '0;
		end else if (cmd.load_blk) begin
			total_q <= total_q + {{(eia1_pkg::BlockW-eia1_pkg::VbitsW){1'b0}}, blk_bits};
		end else if (cmd.save_acc) begin
			acc_q <= prod_q;
		end else if (cmd.load_q) begin
			acc_q <= '0;
			total_q <= '0;
		end
	end

	// serial multiplier: one key bit per step, LSB first
	always_ff @(posedge clk) begin
		if (cmd.load_blk) begin
			mul_v_q <= acc_q ^ blk_masked;
			mul_k_q <= key_p_q;
			prod_q <= '0;
			last_q <= final_block;
		end else if (cmd.load_q) begin
			mul_v_q <= prod_q ^ total_q;
			mul_k_q <= key_q_q;
			prod_q <= '0;
		end else if (cmd.step) begin
			if (mul_k_q[0]) prod_q <= prod_q ^ mul_v_q;
			mul_v_q <= eia1_pkg::gf_times_x(mul_v_q);
			mul_k_q <= mul_k_q >> 1;
		end
	end

	// tag register
	always_ff @(posedge clk) begin
		if (cmd.emit) tag_q <= prod_q[eia1_pkg::BlockW-1 -: eia1_pkg::TagW] ^ mask_q;
	end

	assign stat.last_blk = last_q;
	assign mac_tag = tag_q;

endmodule

// ===== hdl/eia1_ctrl.sv =====
// Controller of the EIA1 MAC: state machine, multiply step counter and
// output valid flag. Uses eia1_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eia1_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  eia1_pkg::dp_stat_t   stat,
	output eia1_pkg::dp_cmd_t    cmd
);

	eia1_pkg::state_t state_q, state_d;
	logic [eia1_pkg::CntW-1:0] cnt_q;
	logic out_valid_q;
	logic cnt_done, slot_free;

	assign cnt_done = (cnt_q == eia1_pkg::CntW'(eia1_pkg::MulSteps - 1));
	assign slot_free = !out_valid_q || m_tready;

	// state register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eia1_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.step) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			eia1_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_blk = 1'b1;
					state_d = eia1_pkg::ST_MUL_P;
				end
			end
			eia1_pkg::ST_MUL_P: begin
				cmd.step = 1'b1;
				if (cnt_done) state_d = eia1_pkg::ST_POST_P;
			end
			eia1_pkg::ST_POST_P: begin
				if (stat.last_blk) begin
					cmd.load_q = 1'b1;
					state_d = eia1_pkg::ST_MUL_Q;
				end else begin
					cmd.save_acc = 1'b1;
					state_d = eia1_pkg::ST_IDLE;
				end
			end
			eia1_pkg::ST_MUL_Q: begin
				cmd.step = 1'b1;
				if (cnt_done) state_d = eia1_pkg::ST_POST_Q;
			end
			eia1_pkg::ST_POST_Q: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d = eia1_pkg::ST_IDLE;
				end
			end
			default: state_d = eia1_pkg::ST_IDLE;
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;

	// checks
	`ASSERT_NEVER(a_emit_overwrite, clk, arst_n, cmd.emit && out_valid_q && !m_tready)
	`ASSERT_PROP(a_accept_starts, clk, arst_n, (s_tvalid && s_tready) |=> (state_q == eia1_pkg::ST_MUL_P && cnt_q == '0))
	`ASSERT_PROP(a_mul_ends, clk, arst_n, (state_q == eia1_pkg::ST_MUL_P && cnt_done) |=> state_q == eia1_pkg::ST_POST_P)
	`ASSERT_PROP(a_tag_shown, clk, arst_n, cmd.emit |=> out_valid_q)
	`ASSERT_NEVER(a_step_outside_mul, clk, arst_n, cmd.step && state_q != eia1_pkg::ST_MUL_P && state_q != eia1_pkg::ST_MUL_Q)

endmodule
